[hdl/pdpc_pkg.sv]
// Package for the prime and distinct-prime counter.
// Shared item types and constants; no dependencies.
package pdpc_pkg;

	localparam int unsigned ValueWidth = 32;
	localparam int unsigned MagWidth   = 31;
	localparam int unsigned OutWidth   = 16;

	typedef struct packed {
		logic signed [ValueWidth-1:0] element_value;
		logic                         last_element;
	} in_item_t;

	typedef struct packed {
		logic [OutWidth-1:0] prime_total;
		logic [OutWidth-1:0] distinct_primes;
		logic                table_overflow;
	} out_item_t;

	// front to back: a classified element
	typedef struct packed {
		logic                is_prime;
		logic [MagWidth-1:0] value;
		logic                last;
	} job_t;

endpackage

[hdl/pdpc_if.sv]
// Valid/ready channel interfaces for the counter.
// Depends on pdpc_pkg.
interface pdpc_in_if;
	logic              valid;
	logic              ready;
	pdpc_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pdpc_out_if;
	logic               valid;
	logic               ready;
	pdpc_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/pdpc_ram.sv]
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module pdpc_ram #(
	parameter int unsigned WIDTH = 31,
	parameter int unsigned DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[hdl/pdpc_front.sv]
// Front part: accepts elements and tests primality by trial division.
// Uses pdpc_pkg and pdpc_in_if; divisor remainder via bit-serial divider.
module pdpc_front (
	input  logic          clk,
	input  logic          arst_n,
	pdpc_in_if.sink       in_ch,
	output logic          job_valid,
	output pdpc_pkg::job_t job,
	input  logic          job_ready
);
	localparam int unsigned MW = pdpc_pkg::MagWidth;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_NEXT = 4'b0100,
		S_DONE = 4'b1000
	} fstate_t;

	fstate_t          state_q;
	logic [MW-1:0]    val_q;
	logic             last_q;
	logic             prime_q;
	logic [15:0]      div_q;
	logic [MW-1:0]    rem_q;
	logic [5:0]       bit_q;
	logic [31:0]      sq;
	logic [MW:0]      trial;
	logic [MW-1:0]    rem_sh;

	assign in_ch.ready = (state_q == S_IDLE);
	assign sq = 32'(div_q) * 32'(div_q);
	assign rem_sh = {rem_q[MW-2:0], val_q[5'(bit_q - 6'd1)]};
	assign trial = {1'b0, rem_sh} - {16'd0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						val_q   <= in_ch.data.element_value[MW-1:0];
						last_q  <= in_ch.data.last_element;
						div_q   <= 16'd2;
						if (in_ch.data.element_value[MW] ||
						    in_ch.data.element_value[MW-1:0] < 31'd2) begin
							prime_q <= 1'b0;
							state_q <= S_DONE;
						end else begin
							prime_q <= 1'b1;
							state_q <= S_NEXT;
						end
					end
				end
				S_NEXT: begin
					if (sq > 32'(val_q) || div_q == 16'hFFFF) begin
						state_q <= S_DONE;
					end else begin
						rem_q   <= '0;
						bit_q   <= 6'(MW);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= trial[MW] ? rem_sh : trial[MW-1:0];
					bit_q <= bit_q - 6'd1;
					if (bit_q == 6'd1) begin
						if ((trial[MW] ? rem_sh : trial[MW-1:0]) == '0) begin
							prime_q <= 1'b0;
							state_q <= S_DONE;
						end else begin
							div_q   <= div_q + 16'd1;
							state_q <= S_NEXT;
						end
					end
				end
				S_DONE: begin
					if (job_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign job_valid    = (state_q == S_DONE);
	assign job.is_prime = prime_q;
	assign job.value    = val_q;
	assign job.last     = last_q;

`ifndef SYNTHESIS
	a_div_ge2: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> div_q >= 16'd2) else $error("divisor below two");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && !job_ready |=> job_valid && $stable(job)) else $error("job lost");
	a_prime_pos: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job.is_prime |-> job.value >= 31'd2) else $error("bad prime");
`endif
endmodule

[hdl/pdpc_queue.sv]
// Two-entry queue between front and back parts.
// Uses pdpc_pkg.
module pdpc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	input  pdpc_pkg::job_t wr_data,
	output logic           wr_ready,
	output logic           rd_valid,
	output pdpc_pkg::job_t rd_data,
	input  logic           rd_ready
);
	pdpc_pkg::job_t mem_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop  = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

`ifndef SYNTHESIS
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue count");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 && !pop |=> cnt_q == 2'd2) else $error("queue full drop");
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> wp_q == rp_q) else $error("queue ptr");
`endif
endmodule

[hdl/pdpc_back.sv]
// Back part: searches the seen-primes table, updates counts, reports.
// Uses pdpc_pkg, pdpc_out_if and pdpc_ram.
module pdpc_back #(
	parameter int unsigned TABLE_DEPTH = 256,
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  pdpc_pkg::job_t job,
	output logic           job_ready,
	pdpc_out_if.source     out_ch
);
	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned FW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned MW = pdpc_pkg::MagWidth;
	localparam int unsigned OW = pdpc_pkg::OutWidth;
	localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_RD   = 5'b00010,
		B_CMP  = 5'b00100,
		B_UPD  = 5'b01000,
		B_OUT  = 5'b10000
	} bstate_t;

	bstate_t              state_q;
	logic [COUNT_WIDTH-1:0] ptally_q, dtally_q;
	logic [FW-1:0]        fill_q, idx_q;
	logic                 ovf_q, found_q;
	logic [MW-1:0]        val_q;
	logic                 last_q;
	logic [MW-1:0]        rdata;
	logic                 we;

	assign job_ready = (state_q == B_IDLE);
	assign we = (state_q == B_UPD) && !found_q && (fill_q < FW'(TABLE_DEPTH));

	pdpc_ram #(.WIDTH(MW), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(fill_q[AW-1:0]), .wdata(val_q),
		.raddr(idx_q[AW-1:0]), .rdata(rdata)
	);

	function automatic logic [OW-1:0] clamp(input logic [COUNT_WIDTH-1:0] c);
		if (COUNT_WIDTH > OW && c > COUNT_WIDTH'(17'h0FFFF)) return '1;
		return OW'(c);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			ptally_q <= '0; dtally_q <= '0; fill_q <= '0; ovf_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						val_q   <= job.value;
						last_q  <= job.last;
						idx_q   <= '0;
						found_q <= 1'b0;
						if (!job.is_prime) state_q <= job.last ? B_OUT : B_IDLE;
						else if (fill_q == '0) state_q <= B_UPD;
						else state_q <= B_RD;
					end
				end
				B_RD: state_q <= B_CMP;
				B_CMP: begin
					if (rdata == val_q) begin
						found_q <= 1'b1;
						state_q <= B_UPD;
					end else if (idx_q + FW'(1) >= fill_q) begin
						state_q <= B_UPD;
					end else begin
						idx_q   <= idx_q + FW'(1);
						state_q <= B_RD;
					end
				end
				B_UPD: begin
					if (ptally_q != CountMax) ptally_q <= ptally_q + COUNT_WIDTH'(1);
					if (!found_q) begin
						if (fill_q < FW'(TABLE_DEPTH)) begin
							fill_q <= fill_q + FW'(1);
							if (dtally_q != CountMax) dtally_q <= dtally_q + COUNT_WIDTH'(1);
						end else ovf_q <= 1'b1;
					end
					state_q <= last_q ? B_OUT : B_IDLE;
				end
				B_OUT: begin
					if (out_ch.ready) begin
						ptally_q <= '0; dtally_q <= '0; fill_q <= '0; ovf_q <= 1'b0;
						state_q  <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_ch.valid                = (state_q == B_OUT);
	assign out_ch.data.prime_total     = clamp(ptally_q);
	assign out_ch.data.distinct_primes = clamp(dtally_q);
	assign out_ch.data.table_overflow  = ovf_q;

`ifndef SYNTHESIS
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(TABLE_DEPTH)) else $error("fill overrun");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_CMP |-> idx_q < fill_q) else $error("read beyond fill");
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> fill_q == FW'(TABLE_DEPTH)) else $error("overflow early");
`endif
endmodule

[hdl/prime_and_distinct_prime_counter_core.sv]
// Top level of the prime and distinct-prime counter.
// Depends on pdpc_pkg, pdpc_if, pdpc_front, pdpc_queue, pdpc_back.
//
//  channel  dir  payload
//  in_ch    in   element_value[31:0] signed, last_element
//  out_ch   out  prime_total[15:0], distinct_primes[15:0], table_overflow
//
// Front: per divisor d up to sqrt(value), a bound check then a 31-step remainder.
// Up to ~46k divisors are tried for a large prime; non-primes stop early.
// Back: each table entry searched takes a RAM read state and a compare state; fill up to TABLE_DEPTH.
// A two-entry queue lets the front test the next item while the back searches.
// Reset clears counts and fill; the table needs no clearing pass.
module prime_and_distinct_prime_counter_core #(
	parameter int unsigned TABLE_DEPTH = 256,
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	pdpc_in_if.sink    in_ch,
	pdpc_out_if.source out_ch
);
	logic           fj_valid, fj_ready, bj_valid, bj_ready;
	pdpc_pkg::job_t fj, bj;

	pdpc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.job_valid(fj_valid), .job(fj), .job_ready(fj_ready)
	);

	pdpc_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fj_valid), .wr_data(fj), .wr_ready(fj_ready),
		.rd_valid(bj_valid), .rd_data(bj), .rd_ready(bj_ready)
	);

	pdpc_back #(.TABLE_DEPTH(TABLE_DEPTH), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(bj_valid), .job(bj), .job_ready(bj_ready), .out_ch(out_ch)
	);
endmodule
